[sv/compass_heading_calibrated_macros.svh]
// assertion macros shared by the compass heading rtl
// no dependencies; files that check properties include this header
`ifndef COMPASS_HEADING_CALIBRATED_MACROS_SVH
`define COMPASS_HEADING_CALIBRATED_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every clock edge outside reset
`define CHC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define CHC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CHC_ASSERT(name, clk, rst, prop, msg)
`define CHC_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

[sv/chc_pkg.sv]
// constants, flag type and arctangent table of the compass heading block
// no dependencies; used by the channel interfaces and every module
package chc_pkg;

   localparam int CHC_CORDIC_STAGES = 16;
   localparam int CHC_SAMPLE_BITS   = 12;

   localparam int RAW_W       = 12;
   localparam int TIME_W      = 32;
   localparam int DECL_W      = 15;
   localparam int HEADING_W   = 15;
   localparam int ANGLE_W     = 24;
   localparam int CSR_ADDR_W  = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [TIME_W-1:0]         WINDOW_RESET = 32'd10000;
   localparam logic signed [DECL_W-1:0]  DECL_RESET   = 15'sd151;
   // 180 degrees in 1/16384 degree
   localparam logic signed [ANGLE_W-1:0] ANG_180      = 24'sd2949120;
   localparam logic [HEADING_W-1:0]      FULL_TURN    = 15'd23040;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW      = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECLINATION = 8'd1;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef struct packed {
      logic calibrating;
      logic heading_ok;
      logic at_origin;
   } chc_flags_type;

   // atan(2^-i) in 1/16384 degree, rounded to nearest
   function automatic logic signed [ANGLE_W-1:0] chc_atan(input int unsigned stage);
      case (stage)
         0:  return 24'sd737280;
         1:  return 24'sd435242;
         2:  return 24'sd229970;
         3:  return 24'sd116736;
         4:  return 24'sd58595;
         5:  return 24'sd29326;
         6:  return 24'sd14667;
         7:  return 24'sd7334;
         8:  return 24'sd3667;
         9:  return 24'sd1833;
         10: return 24'sd917;
         11: return 24'sd458;
         12: return 24'sd229;
         13: return 24'sd115;
         14: return 24'sd57;
         15: return 24'sd29;
         16: return 24'sd14;
         17: return 24'sd7;
         18: return 24'sd4;
         19: return 24'sd2;
         20: return 24'sd1;
         default: return '0;
      endcase
   endfunction

endpackage

[sv/chc_if.sv]
// valid/ready channel interfaces of the compass heading block
// depends on chc_pkg for field widths
interface chc_req_if import chc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [TIME_W-1:0]        now_ms;
   logic signed [RAW_W-1:0]  x_sample;
   logic signed [RAW_W-1:0]  y_sample;

   modport source (output valid, op, now_ms, x_sample, y_sample, input ready);
   modport sink (input valid, op, now_ms, x_sample, y_sample, output ready);
endinterface

interface chc_rsp_if import chc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [HEADING_W-1:0]  heading;
   logic                  heading_valid;
   logic                  calibrating;

   modport source (output valid, heading, heading_valid, calibrating, input ready);
   modport sink (input valid, heading, heading_valid, calibrating, output ready);
endinterface

interface chc_csr_if import chc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_ADDR_W-1:0]  addr;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

[sv/chc_calib.sv]
// first stage: sample saturation, calibration window test, min/max tracking
// depends on chc_pkg and compass_heading_calibrated_macros.svh
`include "compass_heading_calibrated_macros.svh"

module chc_calib import chc_pkg::*; #(
   parameter int SAMPLE_BITS = CHC_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          op,
   input  logic [TIME_W-1:0]             now_ms,
   input  logic signed [RAW_W-1:0]       x_sample,
   input  logic signed [RAW_W-1:0]       y_sample,
   input  logic [TIME_W-1:0]             window_ms,
   output logic                          out_valid,
   input  logic                          out_ready,
   output chc_flags_type                 out_flags,
   output logic signed [SAMPLE_BITS-1:0] out_x,
   output logic signed [SAMPLE_BITS-1:0] out_y,
   output logic signed [SAMPLE_BITS-1:0] out_x_low,
   output logic signed [SAMPLE_BITS-1:0] out_x_high,
   output logic signed [SAMPLE_BITS-1:0] out_y_low,
   output logic signed [SAMPLE_BITS-1:0] out_y_high
);

   localparam int EW = (SAMPLE_BITS > RAW_W) ? SAMPLE_BITS : RAW_W;
   localparam logic signed [EW-1:0] SAT_HI = EW'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [EW-1:0] SAT_LO = EW'(-(1 << (SAMPLE_BITS - 1)));

   function automatic logic signed [SAMPLE_BITS-1:0] saturate(
      input logic signed [RAW_W-1:0] raw);
      logic signed [EW-1:0] v;
      v = EW'(raw);
      if (v > SAT_HI) begin
         v = SAT_HI;
      end else if (v < SAT_LO) begin
         v = SAT_LO;
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   logic [TIME_W-1:0]             start_ff;
   logic signed [SAMPLE_BITS-1:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic signed [SAMPLE_BITS-1:0] x_low_in, x_high_in, y_low_in, y_high_in;
   logic signed [SAMPLE_BITS-1:0] xs, ys;
   logic signed [SAMPLE_BITS-1:0] x_ff, y_ff;
   logic signed [SAMPLE_BITS-1:0] snap_x_low_ff, snap_x_high_ff;
   logic signed [SAMPLE_BITS-1:0] snap_y_low_ff, snap_y_high_ff;
   logic [TIME_W-1:0]             elapsed;
   logic                          in_window;
   logic                          accept;
   logic                          is_sample;
   logic                          valid_ff;
   chc_flags_type                 flags_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign is_sample = (op == OP_SAMPLE);

   assign xs = saturate(x_sample);
   assign ys = saturate(y_sample);

   // wrapped time since the last restart
   assign elapsed   = now_ms - start_ff;
   assign in_window = (elapsed <= window_ms);

   always_comb begin
      x_low_in  = (in_window && (xs < x_low_ff))  ? xs : x_low_ff;
      x_high_in = (in_window && (xs > x_high_ff)) ? xs : x_high_ff;
      y_low_in  = (in_window && (ys < y_low_ff))  ? ys : y_low_ff;
      y_high_in = (in_window && (ys > y_high_ff)) ? ys : y_high_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         start_ff  <= '0;
         x_low_ff  <= '0;
         x_high_ff <= '0;
         y_low_ff  <= '0;
         y_high_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (accept) begin
            if (is_sample) begin
               x_low_ff  <= x_low_in;
               x_high_ff <= x_high_in;
               y_low_ff  <= y_low_in;
               y_high_ff <= y_high_in;
            end else begin
               start_ff <= now_ms;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff           <= xs;
         y_ff           <= ys;
         snap_x_low_ff  <= x_low_in;
         snap_x_high_ff <= x_high_in;
         snap_y_low_ff  <= y_low_in;
         snap_y_high_ff <= y_high_in;
         flags_ff       <= '{calibrating: is_sample && in_window,
                             heading_ok:  is_sample,
                             at_origin:   1'b0};
      end
   end

   assign out_valid  = valid_ff;
   assign out_flags  = flags_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_x_low  = snap_x_low_ff;
   assign out_x_high = snap_x_high_ff;
   assign out_y_low  = snap_y_low_ff;
   assign out_y_high = snap_y_high_ff;

   `CHC_ASSERT(a_x_order, clock, reset, x_low_ff <= x_high_ff, "x minimum above x maximum")
   `CHC_ASSERT(a_y_order, clock, reset, y_low_ff <= y_high_ff, "y minimum above y maximum")

endmodule

[sv/chc_scale.sv]
// second stage: spans, centring and cross-multiplied scaling of the sample
// depends on chc_pkg
module chc_scale import chc_pkg::*; #(
   parameter int SAMPLE_BITS = CHC_SAMPLE_BITS,
   parameter int DATA_W      = 2 * CHC_SAMPLE_BITS + 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  chc_flags_type                 in_flags,
   input  logic signed [SAMPLE_BITS-1:0] in_x,
   input  logic signed [SAMPLE_BITS-1:0] in_y,
   input  logic signed [SAMPLE_BITS-1:0] in_x_low,
   input  logic signed [SAMPLE_BITS-1:0] in_x_high,
   input  logic signed [SAMPLE_BITS-1:0] in_y_low,
   input  logic signed [SAMPLE_BITS-1:0] in_y_high,
   output logic                          out_valid,
   input  logic                          out_ready,
   output chc_flags_type                 out_flags,
   output logic signed [DATA_W-1:0]      out_x,
   output logic signed [DATA_W-1:0]      out_y
);

   localparam int SW = SAMPLE_BITS + 1;
   localparam int CW = SAMPLE_BITS + 2;
   localparam int PW = 2 * SAMPLE_BITS + 3;

   logic signed [SW-1:0]     span_x, span_y;
   logic signed [CW-1:0]     cen_x, cen_y;
   logic signed [PW-1:0]     prod_x, prod_y;
   logic                     span_ok;
   logic                     valid_ff;
   chc_flags_type            flags_ff;
   logic signed [DATA_W-1:0] x_ff, y_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      span_x  = SW'(in_x_high) - SW'(in_x_low);
      span_y  = SW'(in_y_high) - SW'(in_y_low);
      // doubled sample minus doubled midpoint
      cen_x   = (CW'(in_x) <<< 1) - (CW'(in_x_low) + CW'(in_x_high));
      cen_y   = (CW'(in_y) <<< 1) - (CW'(in_y_low) + CW'(in_y_high));
      prod_x  = PW'(cen_x) * PW'(span_y);
      prod_y  = PW'(cen_y) * PW'(span_x);
      span_ok = !span_x[SW-1] && (span_x != '0) && !span_y[SW-1] && (span_y != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff     <= DATA_W'(prod_x);
         y_ff     <= DATA_W'(prod_y);
         flags_ff <= '{calibrating: in_flags.calibrating,
                       heading_ok:  in_flags.heading_ok && span_ok,
                       at_origin:   1'b0};
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule

[sv/chc_quadrant.sv]
// pre-rotation cell: folds the left half plane onto the right, seeds the angle
// depends on chc_pkg
module chc_quadrant import chc_pkg::*; #(
   parameter int DATA_W = 2 * CHC_SAMPLE_BITS + 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  chc_flags_type             in_flags,
   input  logic signed [DATA_W-1:0]  in_x,
   input  logic signed [DATA_W-1:0]  in_y,
   output logic                      out_valid,
   input  logic                      out_ready,
   output chc_flags_type             out_flags,
   output logic signed [DATA_W-1:0]  out_x,
   output logic signed [DATA_W-1:0]  out_y,
   output logic signed [ANGLE_W-1:0] out_z
);

   logic                      valid_ff;
   chc_flags_type             flags_ff;
   logic signed [DATA_W-1:0]  x_ff, y_ff, x_in, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic                      origin;

   assign in_ready = !valid_ff || out_ready;
   assign origin   = (in_x == '0) && (in_y == '0);

   always_comb begin
      x_in = in_x;
      y_in = in_y;
      z_in = '0;
      if (in_x[DATA_W-1]) begin
         x_in = -in_x;
         y_in = -in_y;
         z_in = in_y[DATA_W-1] ? -ANG_180 : ANG_180;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         flags_ff <= '{calibrating: in_flags.calibrating,
                       heading_ok:  in_flags.heading_ok,
                       at_origin:   origin};
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

[sv/chc_cordic_cell.sv]
// one vectoring cordic cell: a shift-add micro-rotation and its angle step
// depends on chc_pkg
module chc_cordic_cell import chc_pkg::*; #(
   parameter int STAGE  = 0,
   parameter int DATA_W = 2 * CHC_SAMPLE_BITS + 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  chc_flags_type             in_flags,
   input  logic signed [DATA_W-1:0]  in_x,
   input  logic signed [DATA_W-1:0]  in_y,
   input  logic signed [ANGLE_W-1:0] in_z,
   output logic                      out_valid,
   input  logic                      out_ready,
   output chc_flags_type             out_flags,
   output logic signed [DATA_W-1:0]  out_x,
   output logic signed [DATA_W-1:0]  out_y,
   output logic signed [ANGLE_W-1:0] out_z
);

   localparam logic signed [ANGLE_W-1:0] STEP = chc_atan(STAGE);

   logic                      valid_ff;
   chc_flags_type             flags_ff;
   logic signed [DATA_W-1:0]  x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic                      rot_neg;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      dx      = in_y >>> STAGE;
      dy      = in_x >>> STAGE;
      // rotate clockwise while y is above the axis
      rot_neg = !in_y[DATA_W-1] && (in_y != '0);
      if (rot_neg) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + STEP;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

[sv/chc_wrap.sv]
// output stage: declination, rounding to 1/64 degree, wrap into one turn
// depends on chc_pkg
module chc_wrap import chc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  chc_flags_type             in_flags,
   input  logic signed [ANGLE_W-1:0] in_z,
   input  logic signed [DECL_W-1:0]  declination,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [HEADING_W-1:0]      heading,
   output logic                      heading_valid,
   output logic                      calibrating
);

   localparam int SUM_W = ANGLE_W + 2;
   localparam int HW    = SUM_W - 8;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(128);
   localparam logic signed [HW-1:0]    TURN       = HW'(FULL_TURN);

   logic signed [SUM_W-1:0]  z_ext, decl_ext, sum;
   logic signed [HW-1:0]     deg, wrapped;
   logic [HEADING_W-1:0]     heading_in;
   logic                     valid_ff;
   logic [HEADING_W-1:0]     heading_ff;
   logic                     heading_valid_ff;
   logic                     calibrating_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      z_ext    = in_flags.at_origin ? '0 : SUM_W'(in_z);
      decl_ext = SUM_W'(declination);
      sum      = z_ext + (decl_ext <<< 8) + ROUND_HALF;
      deg      = sum[SUM_W-1:8];
      // value lies within two turns either side of zero
      if (deg < -TURN) begin
         wrapped = deg + (TURN <<< 1);
      end else if (deg < 0) begin
         wrapped = deg + TURN;
      end else if (deg >= TURN) begin
         wrapped = deg - TURN;
      end else begin
         wrapped = deg;
      end
      heading_in = in_flags.heading_ok ? wrapped[HEADING_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         heading_ff       <= heading_in;
         heading_valid_ff <= in_flags.heading_ok;
         calibrating_ff   <= in_flags.calibrating;
      end
   end

   assign out_valid     = valid_ff;
   assign heading       = heading_ff;
   assign heading_valid = heading_valid_ff;
   assign calibrating   = calibrating_ff;

endmodule

[sv/compass_heading_calibrated.sv]
// Calibrated compass heading from magnetometer x/y samples.
// req_ch carries an op (sample or calibration restart), a millisecond
// timestamp and the raw x/y readings; rsp_ch returns one transfer per request
// with the heading in 1/64 degree, heading_valid and calibrating.
// csr_ch writes calibration_window_ms (addr 0) and declination (addr 1); it is
// always ready and should be written only while the pipeline is empty.
// Registered stages in order: min/max tracking, cross-multiplied scaling, quadrant
// fold, one cell per CORDIC iteration, then declination and wrap. Throughput is
// one request per cycle while rsp_ch is ready; every cell is a register stage
// with its own valid, so a new request is taken while finished results wait in
// the output register.
// When the receiver stalls, results pile up behind the output register and
// req_ch.ready drops only once every stage holds a request.
// Reset empties the pipeline, clears the window start and the x/y minima and
// maxima to zero and loads the window (10000 ms) and declination (151).
// depends on chc_pkg, chc_if, the chc_* stage modules and the macros header
`include "compass_heading_calibrated_macros.svh"

module compass_heading_calibrated import chc_pkg::*; #(
   parameter int CORDIC_STAGES = CHC_CORDIC_STAGES,
   parameter int SAMPLE_BITS   = CHC_SAMPLE_BITS
) (
   input  logic     clock,
   input  logic     reset,
   chc_req_if.sink  req_ch,
   chc_rsp_if.source rsp_ch,
   chc_csr_if.sink  csr_ch
);

   localparam int DATA_W = 2 * SAMPLE_BITS + 5;

   logic [TIME_W-1:0]        window_ff;
   logic signed [DECL_W-1:0] declination_ff;

   logic                          cal_valid, cal_ready;
   chc_flags_type                 cal_flags;
   logic signed [SAMPLE_BITS-1:0] cal_x, cal_y;
   logic signed [SAMPLE_BITS-1:0] cal_x_low, cal_x_high, cal_y_low, cal_y_high;

   logic                          scl_valid, scl_ready;
   chc_flags_type                 scl_flags;
   logic signed [DATA_W-1:0]      scl_x, scl_y;

   logic                      cell_valid [0:CORDIC_STAGES];
   logic                      cell_ready [0:CORDIC_STAGES];
   chc_flags_type             cell_flags [0:CORDIC_STAGES];
   logic signed [DATA_W-1:0]  cell_x     [0:CORDIC_STAGES];
   logic signed [DATA_W-1:0]  cell_y     [0:CORDIC_STAGES];
   logic signed [ANGLE_W-1:0] cell_z     [0:CORDIC_STAGES];

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= WINDOW_RESET;
         declination_ff <= DECL_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            CSR_WINDOW:      window_ff      <= csr_ch.data[TIME_W-1:0];
            CSR_DECLINATION: declination_ff <= csr_ch.data[DECL_W-1:0];
            default: ;
         endcase
      end
   end

   chc_calib #(.SAMPLE_BITS(SAMPLE_BITS)) u_calib (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .op         (req_ch.op),
      .now_ms     (req_ch.now_ms),
      .x_sample   (req_ch.x_sample),
      .y_sample   (req_ch.y_sample),
      .window_ms  (window_ff),
      .out_valid  (cal_valid),
      .out_ready  (cal_ready),
      .out_flags  (cal_flags),
      .out_x      (cal_x),
      .out_y      (cal_y),
      .out_x_low  (cal_x_low),
      .out_x_high (cal_x_high),
      .out_y_low  (cal_y_low),
      .out_y_high (cal_y_high)
   );

   chc_scale #(.SAMPLE_BITS(SAMPLE_BITS), .DATA_W(DATA_W)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cal_valid),
      .in_ready  (cal_ready),
      .in_flags  (cal_flags),
      .in_x      (cal_x),
      .in_y      (cal_y),
      .in_x_low  (cal_x_low),
      .in_x_high (cal_x_high),
      .in_y_low  (cal_y_low),
      .in_y_high (cal_y_high),
      .out_valid (scl_valid),
      .out_ready (scl_ready),
      .out_flags (scl_flags),
      .out_x     (scl_x),
      .out_y     (scl_y)
   );

   chc_quadrant #(.DATA_W(DATA_W)) u_quadrant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scl_valid),
      .in_ready  (scl_ready),
      .in_flags  (scl_flags),
      .in_x      (scl_x),
      .in_y      (scl_y),
      .out_valid (cell_valid[0]),
      .out_ready (cell_ready[0]),
      .out_flags (cell_flags[0]),
      .out_x     (cell_x[0]),
      .out_y     (cell_y[0]),
      .out_z     (cell_z[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      chc_cordic_cell #(.STAGE(i), .DATA_W(DATA_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_ready  (cell_ready[i]),
         .in_flags  (cell_flags[i]),
         .in_x      (cell_x[i]),
         .in_y      (cell_y[i]),
         .in_z      (cell_z[i]),
         .out_valid (cell_valid[i+1]),
         .out_ready (cell_ready[i+1]),
         .out_flags (cell_flags[i+1]),
         .out_x     (cell_x[i+1]),
         .out_y     (cell_y[i+1]),
         .out_z     (cell_z[i+1])
      );
   end

   chc_wrap u_wrap (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cell_valid[CORDIC_STAGES]),
      .in_ready      (cell_ready[CORDIC_STAGES]),
      .in_flags      (cell_flags[CORDIC_STAGES]),
      .in_z          (cell_z[CORDIC_STAGES]),
      .declination   (declination_ff),
      .out_valid     (rsp_ch.valid),
      .out_ready     (rsp_ch.ready),
      .heading       (rsp_ch.heading),
      .heading_valid (rsp_ch.heading_valid),
      .calibrating   (rsp_ch.calibrating)
   );

   `CHC_ASSERT(a_heading_range, clock, reset, rsp_ch.valid |-> (rsp_ch.heading < FULL_TURN), "heading outside one turn")
   `CHC_ASSERT(a_invalid_zero, clock, reset, (rsp_ch.valid && !rsp_ch.heading_valid) |-> (rsp_ch.heading == '0), "invalid heading not zero")
   `CHC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_ch.valid, "result offered right after reset")

endmodule

[verif/tb_compass_heading_calibrated.sv]
`timescale 1ns / 100ps
// self-checking bench for compass_heading_calibrated: directed corner items, then
// random calibration sessions under several register settings, checked in order
// depends on chc_pkg, chc_if and compass_heading_calibrated
module tb_compass_heading_calibrated import chc_pkg::*; ();

   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPE_DRAIN  = 60;
   localparam int ROTATIONS   = 16;
   localparam int PHASE_ITEMS = 300;
   localparam longint HALF_TURN_Q14 = 2949120;
   localparam longint TURN_Q6       = 23040;
   // atan(2^-i) in 1/16384 degree
   localparam longint ARCTAN_Q14 [ROTATIONS] = '{
      737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
      3667, 1833, 917, 458, 229, 115, 57, 29
   };

   typedef struct packed {
      logic                    op;
      logic [TIME_W-1:0]       now_ms;
      logic signed [RAW_W-1:0] x_sample;
      logic signed [RAW_W-1:0] y_sample;
   } heading_req_type;

   typedef struct packed {
      logic [HEADING_W-1:0] heading;
      logic                 heading_valid;
      logic                 calibrating;
   } heading_rsp_type;

   logic clock = 1'b0;
   logic reset;

   chc_req_if req_ch();
   chc_rsp_if rsp_ch();
   chc_csr_if csr_ch();

   compass_heading_calibrated uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and calibration state
   logic [TIME_W-1:0]        window_ms;
   logic signed [DECL_W-1:0] decl_setting;
   logic [TIME_W-1:0]        win_start;
   int                       x_low, x_high, y_low, y_high;

   heading_req_type sample_queue [$];
   heading_rsp_type heading_fifo [$];
   heading_req_type next_item;

   int gap_pct, stall_pct;
   int gap_left, stall_left;
   int cycle_count;
   int mismatch_count;
   int results_checked, valid_headings, invalid_headings, calibrating_hits, restarts;
   int settings_used;

   function automatic longint cordic_bearing(input longint yv, input longint xv);
      longint z, dx, dy;
      int i;
      z = 0;
      if (xv == 0 && yv == 0)
         return 0;
      if (xv < 0) begin
         z = (yv >= 0) ? HALF_TURN_Q14 : -HALF_TURN_Q14;
         xv = -xv;
         yv = -yv;
      end
      for (i = 0; i < ROTATIONS; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv > 0) begin
            xv += dx;
            yv -= dy;
            z += ARCTAN_Q14[i];
         end else begin
            xv -= dx;
            yv += dy;
            z -= ARCTAN_Q14[i];
         end
      end
      return z;
   endfunction

   function automatic heading_rsp_type predict_heading(input heading_req_type it);
      heading_rsp_type r;
      int xs, ys;
      logic [TIME_W-1:0] elapsed;
      longint span_x, span_y, ctr_x, ctr_y, angle, h;
      r = '0;
      if (it.op == OP_RESTART) begin
         // restart keeps the minima and maxima
         win_start = it.now_ms;
         restarts++;
         return r;
      end
      xs = $signed(it.x_sample);
      ys = $signed(it.y_sample);
      elapsed = it.now_ms - win_start;
      r.calibrating = (elapsed <= window_ms);
      if (r.calibrating) begin
         calibrating_hits++;
         if (xs < x_low) x_low = xs;
         if (xs > x_high) x_high = xs;
         if (ys < y_low) y_low = ys;
         if (ys > y_high) y_high = ys;
      end
      span_x = x_high - x_low;
      span_y = y_high - y_low;
      if (span_x <= 0 || span_y <= 0) begin
         invalid_headings++;
         return r;
      end
      // doubled offsets from the midpoint, scaled by the other axis span
      ctr_x = 2 * longint'(xs) - (longint'(x_low) + x_high);
      ctr_y = 2 * longint'(ys) - (longint'(y_low) + y_high);
      angle = cordic_bearing(ctr_y * span_x, ctr_x * span_y);
      h = (angle + longint'(decl_setting) * 256 + 128) >>> 8;
      h = h % TURN_Q6;
      if (h < 0)
         h += TURN_Q6;
      r.heading = h[HEADING_W-1:0];
      r.heading_valid = 1'b1;
      valid_headings++;
      return r;
   endfunction

   function automatic logic signed [RAW_W-1:0] sat_raw(input int v);
      if (v > 2047)
         return 12'sd2047;
      if (v < -2048)
         return -12'sd2048;
      return v[RAW_W-1:0];
   endfunction

   function automatic heading_req_type make_req(input logic op, input logic [TIME_W-1:0] t,
                                                input int x, input int y);
      heading_req_type it;
      it.op = op;
      it.now_ms = t;
      it.x_sample = sat_raw(x);
      it.y_sample = sat_raw(y);
      return it;
   endfunction

   // restart followed by samples around a random center, timestamps drifting
   // through and past the window
   function automatic int queue_session(input logic [TIME_W-1:0] win);
      logic [TIME_W-1:0] t0, t, step;
      int cxo, cyo, r, n, k;
      case ($urandom_range(0, 3))
         0: t0 = 32'hFFFF_FFFF - $urandom_range(0, 20000);
         1: t0 = $urandom_range(0, 20000);
         default: t0 = $urandom();
      endcase
      sample_queue.push_back(make_req(OP_RESTART, t0, $urandom_range(0, 4095) - 2048,
                                      $urandom_range(0, 4095) - 2048));
      n = $urandom_range(4, 30);
      cxo = int'($urandom_range(0, 2400)) - 1200;
      cyo = int'($urandom_range(0, 2400)) - 1200;
      r = $urandom_range(1, 800);
      step = win / 6 + 1;
      t = t0;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 7))
            0: ;
            1, 2, 3, 4: t = t + $urandom_range(1, step);
            5: t = t0 + win + ($urandom() % 2);
            6: t = $urandom();
            default: t = t + $urandom_range(0, 3);
         endcase
         sample_queue.push_back(make_req(OP_SAMPLE, t,
                                         cxo + int'($urandom_range(0, 2 * r)) - r,
                                         cyo + int'($urandom_range(0, 2 * r)) - r));
      end
      return n + 1;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_heading(input heading_rsp_type got);
      heading_rsp_type want;
      results_checked++;
      if (heading_fifo.size() == 0) begin
         report_mismatch($sformatf("unexpected transfer, heading %0d", got.heading));
         return;
      end
      want = heading_fifo.pop_front();
      if (got.heading !== want.heading)
         report_mismatch($sformatf("heading %0d, want %0d", got.heading, want.heading));
      if (got.heading_valid !== want.heading_valid)
         report_mismatch($sformatf("heading_valid %b, want %b",
                                   got.heading_valid, want.heading_valid));
      if (got.calibrating !== want.calibrating)
         report_mismatch($sformatf("calibrating %b, want %b",
                                   got.calibrating, want.calibrating));
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.addr <= addr;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (addr == CSR_WINDOW)
         window_ms = data;
      else if (addr == CSR_DECLINATION)
         decl_setting = data[DECL_W-1:0];
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (sample_queue.size() != 0 || heading_fifo.size() != 0);
   endtask

   // driver: expectation is formed when an item is put on the bus, in bus order
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left != 0) begin
            req_ch.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (sample_queue.size() != 0) begin
            next_item = sample_queue.pop_front();
            heading_fifo.push_back(predict_heading(next_item));
            req_ch.valid <= 1'b1;
            req_ch.op <= next_item.op;
            req_ch.now_ms <= next_item.now_ms;
            req_ch.x_sample <= next_item.x_sample;
            req_ch.y_sample <= next_item.y_sample;
            if ($urandom_range(0, 99) < gap_pct)
               gap_left <= $urandom_range(1, 9);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_heading({rsp_ch.heading, rsp_ch.heading_valid, rsp_ch.calibrating});
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, heading_fifo.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int phase, queued, decl;
      logic [TIME_W-1:0] win;
      reset = 1'b1;
      cycle_count = 0;
      req_ch.valid = 1'b0;
      req_ch.op = OP_SAMPLE;
      req_ch.now_ms = '0;
      req_ch.x_sample = '0;
      req_ch.y_sample = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.addr = '0;
      csr_ch.data = '0;
      window_ms = WINDOW_RESET;
      decl_setting = DECL_RESET;
      win_start = '0;
      x_low = 0;
      x_high = 0;
      y_low = 0;
      y_high = 0;
      gap_pct = 30;
      stall_pct = 30;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // zero spans, one flat axis, midpoint, cardinal directions, window edges, wrap
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd0, 0, 0));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd1, -4, 0));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd2, 0, 6));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd3, 4, -6));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd4, 0, 0));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd5, 4, 0));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd6, -4, 0));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd7, 0, 6));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd8, 0, -6));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd9, -4, -6));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd10, 4, 6));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd10000, 2047, -2048));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd10001, -2048, 2047));
      sample_queue.push_back(make_req(OP_RESTART, 32'hFFFF_FF00, -1, -2048));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'h0000_0010, -2048, 2047));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'hFFFF_FEFF, 1000, -1000));
      sample_queue.push_back(make_req(OP_RESTART, 32'd0, 2047, 2047));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'hFFFF_FFFF, -1, -1));
      sample_queue.push_back(make_req(OP_SAMPLE, 32'd10000, 2047, 2047));
      wait_drained();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin win = 32'd10000; decl = 0; gap_pct = 30; stall_pct = 30; end
            1: begin win = 32'd0; decl = 11520; gap_pct = 0; stall_pct = 0; end
            2: begin win = 32'hFFFF_FFFF; decl = -11520; gap_pct = 60; stall_pct = 10; end
            3: begin
               win = $urandom_range(1, 5000);
               decl = 16383;
               gap_pct = 10;
               stall_pct = 60;
            end
            4: begin win = 32'd2000; decl = -16384; gap_pct = 30; stall_pct = 30; end
            default: begin
               // closing stretch runs at full rate on both sides
               win = $urandom_range(0, 100000);
               decl = int'($urandom_range(0, 23040)) - 11520;
               gap_pct = 0;
               stall_pct = 0;
            end
         endcase
         write_register(CSR_WINDOW, win);
         write_register(CSR_DECLINATION, decl);
         settings_used++;
         queued = 0;
         while (queued < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
               queued += queue_session(win);
            end else begin
               sample_queue.push_back(make_req(
                  ($urandom_range(0, 9) == 0) ? OP_RESTART : OP_SAMPLE, $urandom(),
                  $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048));
               queued++;
            end
         end
         // sender holds off until every result of the phase is back
         wait_drained();
      end

      repeat (PIPE_DRAIN) @(posedge clock);
      if (heading_fifo.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", heading_fifo.size()));

      $display("%0d results checked: %0d headings, %0d flagged invalid, %0d restarts",
               results_checked, valid_headings, invalid_headings, restarts);
      $display("%0d samples inside the window over %0d register settings, %0d mismatches",
               calibrating_hits, settings_used, mismatch_count);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/chc_pkg.sv
sv/chc_if.sv
sv/chc_calib.sv
sv/chc_scale.sv
sv/chc_quadrant.sv
sv/chc_cordic_cell.sv
sv/chc_wrap.sv
sv/compass_heading_calibrated.sv
verif/tb_compass_heading_calibrated.sv
